/* rtl/core/text_to_unsigned_parser_assert.svh */
// Assertion macros for the text_to_unsigned_parser RTL, included by ttup_back
`ifndef TEXT_TO_UNSIGNED_PARSER_ASSERT_SVH
`define TEXT_TO_UNSIGNED_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TTUP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TTUP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ttup_pkg.sv */
// Package: types, codes and constants of the text_to_unsigned_parser
package ttup_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int VALUE_FIELD_W   = 64;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_INDEX_BIT   = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic REG_DEFAULT_VALUE = 1'b0;
    localparam logic REG_REJECT_ZERO   = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_   = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [3:0] DIGIT_MAX_OCT = 4'd7;
    localparam logic [3:0] DIGIT_MAX_DEC = 4'd9;
    localparam logic [3:0] DIGIT_TEN     = 4'd10;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_ZERO_X,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    typedef enum logic [2:0] {
        CK_SKIP,
        CK_MINUS,
        CK_PLUS,
        CK_X,
        CK_DIGIT,
        CK_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t kind;
        logic [3:0] digit;
        logic       eot;
    } char_item_t;

endpackage

/* rtl/core/text_to_unsigned_parser.sv */
// Top level: ASCII text to unsigned integer parser with APB configuration
// An end_of_text beat is queued, popped by the back end, then registered onto m_axis_tvalid.
// Throughput: one character beat per cycle while the queue has room; the back end takes one
// queued character a cycle. Stall: an end_of_text beat waits in the four-entry queue while
// a result is held and m_axis_tready is low; s_axis_tready drops only once the queue is full.
// Reset (aresetn low, synchronous) clears parse state, queue, output valid and registers.
module text_to_unsigned_parser #(
    parameter int VALUE_WIDTH = ttup_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ttup_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ttup_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ttup_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // ch
    input  logic [0:0]                          s_axis_tuser,  // no_char
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ttup_pkg::VALUE_FIELD_W-1:0]  m_axis_tdata,  // value
    output logic [1:0]                          m_axis_tuser   // used_default, saturated
);
    import ttup_pkg::*;

    logic [CFG_DATA_W-1:0]  default_value_reg, default_value_next;
    logic                   reject_zero_reg, reject_zero_next;
    logic                   cfg_write;

    logic                   q_push, q_full, q_pop, q_valid;
    char_item_t             push_item, pop_item;
    logic [VALUE_WIDTH-1:0] value;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        default_value_next = default_value_reg;
        reject_zero_next   = reject_zero_reg;
        if (cfg_write) begin
            if (paddr[CFG_INDEX_BIT] == REG_DEFAULT_VALUE) begin
                default_value_next = pwdata;
            end else begin
                reject_zero_next = pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_value_reg <= '0;
            reject_zero_reg   <= 1'b0;
        end else begin
            default_value_reg <= default_value_next;
            reject_zero_reg   <= reject_zero_next;
        end
    end

    assign prdata = (paddr[CFG_INDEX_BIT] == REG_REJECT_ZERO) ?
                    CFG_DATA_W'(reject_zero_reg) : default_value_reg;

    ttup_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .ch      (s_axis_tdata),
        .no_char (s_axis_tuser[0]),
        .eot     (s_axis_tlast),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (push_item)
    );

    ttup_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (pop_item)
    );

    ttup_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_item         (pop_item),
        .q_pop          (q_pop),
        .default_value  (default_value_reg[VALUE_WIDTH-1:0]),
        .reject_zero    (reject_zero_reg),
        .m_valid        (m_axis_tvalid),
        .m_ready        (m_axis_tready),
        .m_value        (value),
        .m_used_default (m_axis_tuser[0]),
        .m_saturated    (m_axis_tuser[1])
    );

    assign m_axis_tdata = VALUE_FIELD_W'(value);

endmodule

/* rtl/core/ttup_front.sv */
// Front end: accepts character beats, classifies them and tracks NUL termination
module ttup_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          ch,
    input  logic                no_char,
    input  logic                eot,
    input  logic                q_full,
    output logic                q_push,
    output ttup_pkg::char_item_t q_item
);
    import ttup_pkg::*;

    logic closed_reg;
    logic closed_next;
    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        q_item.eot   = eot;
        q_item.digit = 4'd0;
        q_item.kind  = CK_OTHER;
        if (no_char || closed_reg || ch == CH_NUL) begin
            q_item.kind = CK_SKIP;
        end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_VT ||
                     ch == CH_FF || ch == CH_CR) begin
            q_item.kind = CK_SKIP;
        end else if (ch == CH_MINUS) begin
            q_item.kind = CK_MINUS;
        end else if (ch == CH_PLUS) begin
            q_item.kind = CK_PLUS;
        end else if (ch == CH_LX || ch == CH_UX) begin
            q_item.kind = CK_X;
        end else if (ch >= CH_0 && ch <= CH_9) begin
            q_item.kind  = CK_DIGIT;
            q_item.digit = 4'(ch - CH_0);
        end else if (ch >= CH_LA && ch <= CH_LF_) begin
            q_item.kind  = CK_DIGIT;
            q_item.digit = 4'(ch - CH_LA) + DIGIT_TEN;
        end else if (ch >= CH_UA && ch <= CH_UF) begin
            q_item.kind  = CK_DIGIT;
            q_item.digit = 4'(ch - CH_UA) + DIGIT_TEN;
        end
    end

    always_comb begin
        closed_next = closed_reg;
        if (accept) begin
            if (eot) begin
                closed_next = 1'b0;
            end else if (!no_char && ch == CH_NUL) begin
                closed_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            closed_reg <= 1'b0;
        end else begin
            closed_reg <= closed_next;
        end
    end

endmodule

/* rtl/core/ttup_queue.sv */
// Short queue of classified characters between front and back ends
module ttup_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ttup_pkg::char_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output ttup_pkg::char_item_t pop_item
);
    import ttup_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    char_item_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign do_pop   = pop && valid;
    assign pop_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/ttup_back.sv */
// Back end: parse state machine, radix accumulator and result register
module ttup_back #(
    parameter int VALUE_WIDTH = ttup_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  ttup_pkg::char_item_t   q_item,
    output logic                   q_pop,
    input  logic [VALUE_WIDTH-1:0] default_value,
    input  logic                   reject_zero,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_value,
    output logic                   m_used_default,
    output logic                   m_saturated
);
    import ttup_pkg::*;

    localparam int SUM_W = VALUE_WIDTH + 5;

    phase_t                 phase_reg, phase_next, phase_char;
    radix_t                 radix_reg, radix_next, radix_char, load_radix;
    logic                   failed_reg, failed_next, fail_char;
    logic                   overflow_reg, overflow_next, overflow_char;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next, acc_char;
    logic                   load_first, add_en;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg, out_value_next;
    logic                   out_def_reg, out_def_next;
    logic                   out_sat_reg, out_sat_next;

    logic [SUM_W-1:0]       acc_ext, scaled, sum;
    logic                   sum_ovf;
    logic                   digit_in_radix;
    logic                   use_def;
    logic [VALUE_WIDTH-1:0] parsed;

    assign q_pop = q_valid && (!q_item.eot || !out_valid_reg || m_ready);

    always_comb begin
        unique case (radix_reg)
            RADIX_OCT: digit_in_radix = (q_item.digit <= DIGIT_MAX_OCT);
            RADIX_HEX: digit_in_radix = 1'b1;
            default:   digit_in_radix = (q_item.digit <= DIGIT_MAX_DEC);
        endcase
    end

    // next state of the parse phase
    always_comb begin
        phase_char = phase_reg;
        fail_char  = failed_reg;
        load_first = 1'b0;
        load_radix = RADIX_DEC;
        add_en     = 1'b0;
        if (q_pop && !failed_reg && q_item.kind != CK_SKIP) begin
            if (q_item.kind == CK_MINUS) begin
                fail_char = 1'b1;
            end else begin
                unique case (phase_reg)
                    PH_START, PH_SIGN: begin
                        if (q_item.kind == CK_PLUS && phase_reg == PH_START) begin
                            phase_char = PH_SIGN;
                        end else if (q_item.kind == CK_DIGIT && q_item.digit == 4'd0) begin
                            phase_char = PH_ZERO;
                        end else if (q_item.kind == CK_DIGIT &&
                                     q_item.digit <= DIGIT_MAX_DEC) begin
                            phase_char = PH_DIGITS;
                            load_first = 1'b1;
                            load_radix = RADIX_DEC;
                        end else begin
                            fail_char = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (q_item.kind == CK_X) begin
                            phase_char = PH_ZERO_X;
                        end else if (q_item.kind == CK_DIGIT &&
                                     q_item.digit <= DIGIT_MAX_OCT) begin
                            phase_char = PH_DIGITS;
                            load_first = 1'b1;
                            load_radix = RADIX_OCT;
                        end else begin
                            fail_char = 1'b1;
                        end
                    end
                    PH_ZERO_X: begin
                        if (q_item.kind == CK_DIGIT) begin
                            phase_char = PH_DIGITS;
                            load_first = 1'b1;
                            load_radix = RADIX_HEX;
                        end else begin
                            fail_char = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        if (q_item.kind == CK_DIGIT && digit_in_radix) begin
                            add_en = 1'b1;
                        end else begin
                            fail_char = 1'b1;
                        end
                    end
                    default: fail_char = 1'b1;
                endcase
            end
        end
        phase_next  = (q_pop && q_item.eot) ? PH_START : phase_char;
        failed_next = (q_pop && q_item.eot) ? 1'b0 : fail_char;
    end

    // accumulator datapath and result
    always_comb begin
        acc_ext = SUM_W'(acc_reg);
        unique case (radix_reg)
            RADIX_OCT: scaled = acc_ext << 3;
            RADIX_HEX: scaled = acc_ext << 4;
            default:   scaled = (acc_ext << 3) + (acc_ext << 1);
        endcase
        sum     = scaled + SUM_W'(q_item.digit);
        sum_ovf = |sum[SUM_W-1:VALUE_WIDTH];

        acc_char      = acc_reg;
        radix_char    = radix_reg;
        overflow_char = overflow_reg;
        if (load_first) begin
            acc_char   = VALUE_WIDTH'(q_item.digit);
            radix_char = load_radix;
        end else if (add_en && !overflow_reg) begin
            if (sum_ovf) begin
                acc_char      = '1;
                overflow_char = 1'b1;
            end else begin
                acc_char = sum[VALUE_WIDTH-1:0];
            end
        end

        use_def = fail_char || phase_char == PH_SIGN || phase_char == PH_ZERO_X;
        parsed  = (phase_char == PH_DIGITS) ? acc_char : '0;
        if (!use_def && reject_zero && parsed == '0) begin
            use_def = 1'b1;
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_value_next = out_value_reg;
        out_def_next   = out_def_reg;
        out_sat_next   = out_sat_reg;
        if (q_pop && q_item.eot) begin
            out_valid_next = 1'b1;
            out_value_next = use_def ? default_value : parsed;
            out_def_next   = use_def;
            out_sat_next   = !use_def && overflow_char;
        end

        if (q_pop && q_item.eot) begin
            acc_next      = '0;
            radix_next    = RADIX_DEC;
            overflow_next = 1'b0;
        end else begin
            acc_next      = acc_char;
            radix_next    = radix_char;
            overflow_next = overflow_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            radix_reg     <= RADIX_DEC;
            failed_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            failed_reg    <= failed_next;
            overflow_reg  <= overflow_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
        out_def_reg   <= out_def_next;
        out_sat_reg   <= out_sat_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_value        = out_value_reg;
    assign m_used_default = out_def_reg;
    assign m_saturated    = out_sat_reg;

`include "text_to_unsigned_parser_assert.svh"

    `TTUP_ASSERT_NOW(a_sat_not_default, aclk, aresetn, out_valid_reg && out_sat_reg, !out_def_reg && out_value_reg == '1, "saturated result must be all ones and not default")
    `TTUP_ASSERT_NOW(a_ovf_acc_ones, aclk, aresetn, overflow_reg, acc_reg == '1 && phase_reg == PH_DIGITS, "overflow flag without saturated accumulator")
    `TTUP_ASSERT_NOW(a_radix_digits, aclk, aresetn, radix_reg != RADIX_DEC, phase_reg == PH_DIGITS, "radix chosen outside digit phase")
    `TTUP_ASSERT_NEXT(a_clear_after_end, aclk, aresetn, q_pop && q_item.eot, phase_reg == PH_START && !failed_reg && !overflow_reg && acc_reg == '0 && out_valid_reg, "parse state not cleared after end of text")

endmodule
